@@ rtl/core/pssc_pkg.sv @@
package pssc_pkg;

	localparam int STATE_WIDTH_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int DAC_MAX_DEF     = 4095;

	localparam int CODE_W     = 12;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 16;
	localparam int USER_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int COEF_W     = 24;
	localparam int Y_W        = 22;
	localparam int W_W        = 43;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_ZERO_CODE            = 3'd0,
		CFG_ANGLE_SCALE                = 3'd1,
		CFG_POSITION_OFFSET_HALF_CODES = 3'd2,
		CFG_POSITION_SCALE             = 3'd3,
		CFG_POSITION_LIMIT             = 3'd4,
		CFG_SAFE_COMMAND               = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] angle_zero_code;
		logic [15:0] angle_scale;
		logic [12:0] position_offset_half_codes;
		logic [15:0] position_scale;
		logic [17:0] position_limit;
		logic [11:0] safe_command;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		angle_zero_code:            12'd2040,
		angle_scale:                16'd6482,
		position_offset_half_codes: 13'd3479,
		position_scale:             16'd5787,
		position_limit:             18'd32768,
		safe_command:               12'd2048
	};

	typedef enum logic [1:0] {
		OP_OBS,
		OP_OUT,
		OP_SCALE,
		OP_RECIP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OBS,
		ST_OUT,
		ST_GAP,
		ST_SCALE,
		ST_RECIP,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		CODE_ZERO,
		CODE_MAX,
		CODE_CALC
	} code_sel_t;

	typedef struct packed {
		logic       load;
		logic       issue;
		logic       finish;
		op_t        op;
		logic [1:0] row;
		logic [2:0] col;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

	localparam coef_t A_COEF [4][4] = '{
		'{ 24'sd40606,   24'sd6344,  -24'sd52,    24'sd564   },
		'{ 24'sd6364,    24'sd46124,  24'sd701,   24'sd79    },
		'{ 24'sd118777, -24'sd117945, 24'sd74095, 24'sd15408 },
		'{-24'sd254522,  24'sd57174, -24'sd10132, 24'sd47330 }
	};

	localparam coef_t B_COEF [4][2] = '{
		'{ 24'sd24655,  -24'sd6377   },
		'{-24'sd6101,    24'sd19438  },
		'{-24'sd66408,   24'sd124217 },
		'{ 24'sd200108, -24'sd64605  }
	};

	localparam coef_t C_COEF [4] = '{
		-24'sd5263144, -24'sd630699, -24'sd925467, -24'sd1548354
	};

	// Ceiling of 2^22 / 5; exact floor division by five for values below 2^22.
	localparam coef_t RECIP_K = 24'sd838861;

	function automatic coef_t coef_of(op_t op, logic [1:0] row, logic [2:0] col,
			logic [15:0] dac);
		coef_t c;
		c = '0;
		case (op)
			OP_OBS: begin
				if (col < 3'd4) begin
					c = A_COEF[row][col[1:0]];
				end else begin
					c = B_COEF[row][col[0]];
				end
			end
			OP_OUT:   c = C_COEF[row];
			OP_SCALE: c = coef_t'({8'd0, dac});
			OP_RECIP: c = RECIP_K;
			default:  c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/pendulum_state_space_controller.sv @@
// Inverted-pendulum observer and controller. Each item on the slave stream carries an angle
// and a cart-position sample; the block scales them, advances a four-entry observer state,
// forms the drive and returns one item with the DAC code and its fault and clamp flags.
// An item passes through an acceptance state, 24 observer multiply-accumulates and 4 drive
// multiply-accumulates on one shared multiplier, a gap state for the drive sum to settle,
// two products on that multiplier that map the drive to a code, and a finish state that
// writes the output register once it is free or being taken. The output
// register lets the next item be accepted while the result still waits on the master
// stream. Configuration registers are written through the cfg port, which is always ready,
// and should be written only while no item is in flight.
module pendulum_state_space_controller #(
	parameter int STATE_WIDTH = pssc_pkg::STATE_WIDTH_DEF,
	parameter int SAMPLE_BITS = pssc_pkg::SAMPLE_BITS_DEF,
	parameter int DAC_MAX     = pssc_pkg::DAC_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// angle_code [11:0], position_code [23:12]
	input  logic [pssc_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// drive_code [11:0], zero [15:12]
	output logic [pssc_pkg::OUT_W-1:0]        m_tdata,
	// position_fault [0], drive_clamped [1]
	output logic [pssc_pkg::USER_W-1:0]       m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pssc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pssc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pssc_pkg::cfg_t                 cfg;
	pssc_pkg::dp_cmd_t              cmd;
	pssc_pkg::dp_stat_t             stat;
	logic [pssc_pkg::CODE_W-1:0]    drive_code;
	logic                           position_fault;
	logic                           drive_clamped;

	pssc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pssc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pssc_dp #(
		.STATE_WIDTH (STATE_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DAC_MAX     (DAC_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.in_data   (s_tdata),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_code  (drive_code),
		.out_fault (position_fault),
		.out_clamp (drive_clamped)
	);

	assign m_tdata = {{(pssc_pkg::OUT_W - pssc_pkg::CODE_W){1'b0}}, drive_code};
	assign m_tuser = {drive_clamped, position_fault};

endmodule

@@ rtl/core/pssc_cfg.sv @@
module pssc_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pssc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pssc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output pssc_pkg::cfg_t                        cfg
);

	pssc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pssc_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			case (pssc_pkg::cfg_idx_t'(cfg_index))
				pssc_pkg::CFG_ANGLE_ZERO_CODE:
					cfg_q.angle_zero_code <= cfg_data[11:0];
				pssc_pkg::CFG_ANGLE_SCALE:
					cfg_q.angle_scale <= cfg_data[15:0];
				pssc_pkg::CFG_POSITION_OFFSET_HALF_CODES:
					cfg_q.position_offset_half_codes <= cfg_data[12:0];
				pssc_pkg::CFG_POSITION_SCALE:
					cfg_q.position_scale <= cfg_data[15:0];
				pssc_pkg::CFG_POSITION_LIMIT:
					cfg_q.position_limit <= cfg_data[17:0];
				pssc_pkg::CFG_SAFE_COMMAND:
					cfg_q.safe_command <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/pssc_ctrl.sv @@
module pssc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                m_tready,
	input  pssc_pkg::dp_stat_t  stat,
	output pssc_pkg::dp_cmd_t   cmd
);

	pssc_pkg::ctrl_state_t state_q, state_n;
	logic [1:0] row_q, row_n;
	logic [2:0] col_q, col_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pssc_pkg::ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_n;
			row_q   <= row_n;
			col_q   <= col_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		row_n      = row_q;
		col_n      = col_q;
		s_tready   = 1'b0;
		cmd        = '0;
		cmd.op     = pssc_pkg::OP_OBS;
		cmd.row    = row_q;
		cmd.col    = col_q;
		case (state_q)
			pssc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					row_n    = '0;
					col_n    = '0;
					state_n  = pssc_pkg::ST_OBS;
				end
			end
			pssc_pkg::ST_OBS: begin
				cmd.issue = 1'b1;
				cmd.op    = pssc_pkg::OP_OBS;
				if (col_q == 3'd5) begin
					col_n = '0;
					row_n = row_q + 2'd1;
					if (row_q == 2'd3) begin
						state_n = pssc_pkg::ST_OUT;
					end
				end else begin
					col_n = col_q + 3'd1;
				end
			end
			pssc_pkg::ST_OUT: begin
				cmd.issue = 1'b1;
				cmd.op    = pssc_pkg::OP_OUT;
				row_n     = row_q + 2'd1;
				if (row_q == 2'd3) begin
					state_n = pssc_pkg::ST_GAP;
				end
			end
			pssc_pkg::ST_GAP: begin
				state_n = pssc_pkg::ST_SCALE;
			end
			pssc_pkg::ST_SCALE: begin
				cmd.issue = 1'b1;
				cmd.op    = pssc_pkg::OP_SCALE;
				state_n   = pssc_pkg::ST_RECIP;
			end
			pssc_pkg::ST_RECIP: begin
				cmd.issue = 1'b1;
				cmd.op    = pssc_pkg::OP_RECIP;
				state_n   = pssc_pkg::ST_FINISH;
			end
			pssc_pkg::ST_FINISH: begin
				if (!stat.out_full || m_tready) begin
					cmd.finish = 1'b1;
					state_n    = pssc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = pssc_pkg::ST_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pssc_pkg::ST_IDLE) && s_tvalid |=>
		(state_q == pssc_pkg::ST_OBS) && (row_q == 2'd0) && (col_q == 3'd0))
		else $error("Accepted item did not start the observer sequence.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pssc_pkg::ST_OBS) && (row_q == 2'd3) && (col_q == 3'd5) |=>
		(state_q == pssc_pkg::ST_OUT) && (row_q == 2'd0))
		else $error("Observer sequence did not hand over to the output sum.");

	assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= 3'd5)
		else $error("Column counter left its range.");

endmodule

@@ rtl/core/pssc_dp.sv @@
module pssc_dp #(
	parameter int STATE_WIDTH = pssc_pkg::STATE_WIDTH_DEF,
	parameter int SAMPLE_BITS = pssc_pkg::SAMPLE_BITS_DEF,
	parameter int DAC_MAX     = pssc_pkg::DAC_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pssc_pkg::dp_cmd_t                 cmd,
	output pssc_pkg::dp_stat_t                stat,
	input  pssc_pkg::cfg_t                    cfg,
	input  logic [pssc_pkg::IN_W-1:0]         in_data,
	input  logic                              m_tready,
	output logic                              out_valid,
	output logic [pssc_pkg::CODE_W-1:0]       out_code,
	output logic                              out_fault,
	output logic                              out_clamp
);

	localparam int SW     = STATE_WIDTH;
	localparam int COEF_W = pssc_pkg::COEF_W;
	localparam int Y_W    = pssc_pkg::Y_W;
	localparam int W_W    = pssc_pkg::W_W;
	localparam int CODE_W = pssc_pkg::CODE_W;
	localparam int FULL_W = SW + COEF_W;
	localparam int PROD_W = SW + COEF_W - 16;
	localparam int ACC_W  = (SW + 9 > 42) ? SW + 9 : 42;
	localparam int SB     = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;

	localparam logic [CODE_W-1:0] SMASK    = CODE_W'((64'd1 << SB) - 64'd1);
	localparam logic [CODE_W-1:0] DAC_CODE = CODE_W'(DAC_MAX);

	localparam longint FULL_SCALE = 64'sd1310720;
	localparam longint LO_W = -((FULL_SCALE + longint'(DAC_MAX) - 1) / longint'(DAC_MAX));
	localparam longint HI_W = ((longint'(DAC_MAX) + 1) * FULL_SCALE + longint'(DAC_MAX) - 1)
		/ longint'(DAC_MAX);

	localparam logic signed [W_W-1:0]   W_LO    = W_W'(LO_W);
	localparam logic signed [W_W-1:0]   W_HI    = W_W'(HI_W);
	localparam logic signed [W_W-1:0]   W_OFS   = W_W'(64'sd655360);
	localparam logic signed [ACC_W-1:0] ST_MAX  = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] ST_MIN  = ~ST_MAX;
	localparam logic signed [ACC_W-1:0] U_MAX   = ACC_W'(64'sd1 <<< 40);
	localparam logic signed [ACC_W-1:0] U_MIN   = -U_MAX;

	logic signed [SW-1:0]     state_q [4];
	logic signed [SW-1:0]     nx_q    [4];
	logic signed [Y_W-1:0]    y0_q, y1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q, u_q;
	logic                     iss_s1;
	pssc_pkg::op_t            op_s1;
	logic [1:0]               row_s1;
	logic [2:0]               col_s1;
	pssc_pkg::code_sel_t      code_sel_q;
	logic                     clamp_q;
	logic                     out_valid_q;
	logic [CODE_W-1:0]        out_code_q;
	logic                     out_fault_q, out_clamp_q;

	logic [CODE_W-1:0]        acode, pcode;
	logic signed [12:0]       adiff;
	logic signed [13:0]       pdiff;
	logic signed [29:0]       aprod;
	logic signed [30:0]       pprod;
	logic signed [SW-1:0]     opnd;
	pssc_pkg::coef_t          coef;
	logic signed [FULL_W-1:0] full;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [ACC_W-1:0]  prod_ext, acc_sum, u_sum, u_sat;
	logic signed [SW-1:0]     nx_d;
	logic signed [W_W-1:0]    w;
	logic signed [23:0]       y1_ext, lim_ext;
	logic                     fault;
	logic [CODE_W-1:0]        code_calc;

	always_comb begin
		acode = in_data[11:0] & SMASK;
		pcode = in_data[23:12] & SMASK;
		adiff = $signed({1'b0, acode}) - $signed({1'b0, cfg.angle_zero_code});
		pdiff = $signed({1'b0, pcode, 1'b0}) - $signed({1'b0, cfg.position_offset_half_codes});
		aprod = adiff * $signed({1'b0, cfg.angle_scale});
		pprod = pdiff * $signed({1'b0, cfg.position_scale});
	end

	always_comb begin
		u_sat = u_q;
		if (u_q > U_MAX) begin
			u_sat = U_MAX;
		end else if (u_q < U_MIN) begin
			u_sat = U_MIN;
		end
		w = W_W'(u_sat) + W_OFS;
	end

	always_comb begin
		case (cmd.op)
			pssc_pkg::OP_OBS: begin
				if (cmd.col < 3'd4) begin
					opnd = state_q[cmd.col[1:0]];
				end else if (cmd.col == 3'd4) begin
					opnd = SW'(y0_q);
				end else begin
					opnd = SW'(y1_q);
				end
			end
			pssc_pkg::OP_OUT:   opnd = nx_q[cmd.row];
			pssc_pkg::OP_SCALE: opnd = SW'(w);
			pssc_pkg::OP_RECIP: opnd = SW'(prod_q);
			default:            opnd = '0;
		endcase
		coef = pssc_pkg::coef_of(cmd.op, cmd.row, cmd.col, 16'(DAC_MAX));
		full = opnd * coef;
		case (cmd.op)
			pssc_pkg::OP_SCALE: prod_d = PROD_W'(full >>> 18);
			pssc_pkg::OP_RECIP: prod_d = PROD_W'(full >>> 22);
			default:            prod_d = PROD_W'(full >>> 16);
		endcase
	end

	always_comb begin
		prod_ext = ACC_W'(prod_q);
		acc_sum  = ((col_s1 == 3'd0) ? '0 : acc_q) + prod_ext;
		u_sum    = ((row_s1 == 2'd0) ? '0 : u_q) + prod_ext;
		if (acc_sum > ST_MAX) begin
			nx_d = SW'(ST_MAX);
		end else if (acc_sum < ST_MIN) begin
			nx_d = SW'(ST_MIN);
		end else begin
			nx_d = SW'(acc_sum);
		end
	end

	always_comb begin
		y1_ext  = 24'(y1_q);
		lim_ext = $signed({6'd0, cfg.position_limit});
		fault   = (y1_ext > lim_ext) || (y1_ext < -lim_ext);
		case (code_sel_q)
			pssc_pkg::CODE_ZERO: code_calc = '0;
			pssc_pkg::CODE_MAX:  code_calc = DAC_CODE;
			pssc_pkg::CODE_CALC: code_calc = prod_q[CODE_W-1:0];
			default:             code_calc = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y0_q <= aprod[29:8];
			y1_q <= pprod[30:9];
		end
		if (cmd.issue) begin
			prod_q <= prod_d;
		end
		if (iss_s1 && (op_s1 == pssc_pkg::OP_OBS)) begin
			acc_q <= acc_sum;
			if (col_s1 == 3'd5) begin
				nx_q[row_s1] <= nx_d;
			end
		end
		if (iss_s1 && (op_s1 == pssc_pkg::OP_OUT)) begin
			u_q <= u_sum;
		end
		if (cmd.issue && (cmd.op == pssc_pkg::OP_SCALE)) begin
			if (w <= W_LO) begin
				code_sel_q <= pssc_pkg::CODE_ZERO;
				clamp_q    <= 1'b1;
			end else if (w >= W_HI) begin
				code_sel_q <= pssc_pkg::CODE_MAX;
				clamp_q    <= 1'b1;
			end else if (w < 0) begin
				code_sel_q <= pssc_pkg::CODE_ZERO;
				clamp_q    <= 1'b0;
			end else begin
				code_sel_q <= pssc_pkg::CODE_CALC;
				clamp_q    <= 1'b0;
			end
		end
		if (cmd.finish) begin
			out_code_q  <= fault ? cfg.safe_command : code_calc;
			out_fault_q <= fault;
			out_clamp_q <= clamp_q;
		end
		op_s1  <= cmd.op;
		row_s1 <= cmd.row;
		col_s1 <= cmd.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				state_q[i] <= '0;
			end
		end else begin
			iss_s1 <= cmd.issue;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < 4; i++) begin
					state_q[i] <= nx_q[i];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign out_code      = out_code_q;
	assign out_fault     = out_fault_q;
	assign out_clamp     = out_clamp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && out_valid_q |-> m_tready)
		else $error("Result written over an item that was not taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("Output became valid without a finished item.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_clamp_q && !out_fault_q |->
		(out_code_q == '0) || (out_code_q == DAC_CODE))
		else $error("Clamped drive is not at an end of the code range.");

endmodule
